// ----- rtl/core/pdpr_pkg.sv -----
package pdpr_pkg;

  localparam int DerivShift   = 24;
  localparam int DerivCapLog  = 46;
  localparam int GainShift    = 16;
  localparam int ChunkBits    = 24;
  localparam int CfgIndexBits = 3;
  localparam int CfgDataBits  = 24;
  localparam int MinBits      = 20;
  localparam int RadiusBits   = 19;
  localparam int GainBits     = 16;
  localparam int PeriodBits   = 24;
  localparam int ForceBits    = 32;

  typedef enum logic [CfgIndexBits-1:0] {
    REG_GAIN_SCALE    = 3'd0,
    REG_KP            = 3'd1,
    REG_KD            = 3'd2,
    REG_SAMPLE_PERIOD = 3'd3,
    REG_RADIUS_LIMIT  = 3'd4,
    REG_MIN_X         = 3'd5,
    REG_MIN_Y         = 3'd6,
    REG_MIN_Z         = 3'd7
  } pdpr_reg_e;

  typedef struct packed {
    logic busy;
    logic done;
  } pdpr_unit_sts_t;

endpackage

// ----- rtl/core/pdpr_mul.sv -----
module pdpr_mul #(
  parameter int MW = 26
) (
  input  logic              clk_i,
  input  logic [MW-1:0]     a_i,
  input  logic [MW-1:0]     b_i,
  output logic [2*MW-1:0]   p_o
);
  logic [2*MW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (2*MW)'(a_i) * (2*MW)'(b_i);
  end

  assign p_o = p_q;

endmodule

// ----- rtl/core/pdpr_div.sv -----
module pdpr_div #(
  parameter int NW = 47,
  parameter int DW = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [NW-1:0]            num_i,
  input  logic [DW-1:0]            den_i,
  output logic [NW-1:0]            quot_o,
  output pdpr_pkg::pdpr_unit_sts_t sts_o
);
  import pdpr_pkg::*;

  localparam int CntW = $clog2(NW + 1);

  logic [NW-1:0]   num_q;
  logic [DW-1:0]   den_q;
  logic [DW-1:0]   rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [DW:0]     trial;
  logic            ge;

  assign trial = {rem_q, num_q[NW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], ge};
      rem_q <= ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
    end
  end

  assign quot_o = num_q;
  assign sts_o  = '{busy: busy_q, done: done_q};

endmodule

// ----- rtl/core/pdpr_sqrt.sv -----
module pdpr_sqrt #(
  parameter int SW = 42
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [SW-1:0]            rad_i,
  output logic [SW/2-1:0]          root_o,
  output pdpr_pkg::pdpr_unit_sts_t sts_o
);
  import pdpr_pkg::*;

  localparam int RTW  = SW / 2;
  localparam int CntW = $clog2(RTW + 1);

  logic [SW-1:0]    rad_q;
  logic [RTW-1:0]   root_q;
  logic [RTW+1:0]   rem_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [RTW+3:0]   rem_sh;
  logic [RTW+3:0]   tv;
  logic             ge;

  assign rem_sh = {rem_q, rad_q[SW-1:SW-2]};
  assign tv     = (RTW+4)'({root_q, 2'b01});
  assign ge     = rem_sh >= tv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(RTW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SW-3:0], 2'b00};
      root_q <= {root_q[RTW-2:0], ge};
      rem_q  <= ge ? (RTW+2)'(rem_sh - tv) : rem_sh[RTW+1:0];
    end
  end

  assign root_o = root_q;
  assign sts_o  = '{busy: busy_q, done: done_q};

endmodule

// ----- rtl/core/pd_position_regulator_3d.sv -----
// Three-axis PD position regulator with one shared multiplier, one shared
// divider and one square root unit stepped by a small sequencer.
// The input channel (in_valid_i, in_stall_o) carries one transaction per
// item: either an origin load or a control tick. A load completes in the
// cycle it is accepted and produces no result. A tick produces one result
// transaction on the output channel (out_valid_o, out_stall_i).
// A first-run tick skips the sphere test, and a tick whose reference is
// pulled onto the sphere adds a square root and the scaling divisions.
// The divider yields one quotient bit a cycle (47 steps per division, one
// division per axis, plus one per axis for the sphere scaling), and the
// square root has 21 steps.
// in_stall_o is high while a tick is being worked on. A finished result
// waits in the output register while out_stall_i is high; the next item is
// accepted meanwhile, and its result is held back until the register frees.
// Configuration writes (cfg_valid_i, cfg_ready_o) are always taken and must
// only be issued while the block is idle.
// Reset clears the origin, the previous error and all control state, and
// loads the register defaults.
module pd_position_regulator_3d #(
  parameter int POSITION_BITS = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                op_i,
  input  logic                                first_run_i,
  input  logic signed [POSITION_BITS-1:0]     vector_x_i,
  input  logic signed [POSITION_BITS-1:0]     vector_y_i,
  input  logic signed [POSITION_BITS-1:0]     vector_z_i,
  input  logic signed [POSITION_BITS-1:0]     meas_x_i,
  input  logic signed [POSITION_BITS-1:0]     meas_y_i,
  input  logic signed [POSITION_BITS-1:0]     meas_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pdpr_pkg::ForceBits-1:0] force_x_o,
  output logic signed [pdpr_pkg::ForceBits-1:0] force_y_o,
  output logic signed [pdpr_pkg::ForceBits-1:0] force_z_o,
  output logic signed [POSITION_BITS-1:0]     ref_x_o,
  output logic signed [POSITION_BITS-1:0]     ref_y_o,
  output logic signed [POSITION_BITS-1:0]     ref_z_o,
  output logic signed [POSITION_BITS:0]       err_x_o,
  output logic signed [POSITION_BITS:0]       err_y_o,
  output logic signed [POSITION_BITS:0]       err_z_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pdpr_pkg::CfgIndexBits-1:0]   cfg_index_i,
  input  logic [pdpr_pkg::CfgDataBits-1:0]    cfg_data_i
);
  import pdpr_pkg::*;

  localparam int P    = POSITION_BITS;
  localparam int RW   = (P + 1 > MinBits) ? P + 1 : MinBits;
  localparam int EW   = RW + 1;
  localparam int DFW  = RW + 2;
  localparam int NW   = DFW + DerivShift;
  localparam int DCW  = DerivCapLog + 1;
  localparam int SQW  = 2 * P + 2;
  localparam int RTW  = P + 1;
  localparam int DENW = (RTW > PeriodBits) ? RTW : PeriodBits;
  localparam int MW   = (RW + 1 > 26) ? RW + 1 : 26;
  localparam int PW   = 2 * MW;
  localparam int T1W  = RW + GainBits + 1;
  localparam int T2W  = GainBits + DCW;
  localparam int PDW  = T2W + 2;
  localparam int PMW  = PDW - 1;
  localparam int ACW  = PMW + GainBits;
  localparam int QW   = ACW - GainShift;

  localparam logic [NW:0]  DerivCap    = (NW+1)'(1) << DerivCapLog;
  localparam logic [QW-1:0] ForceMaxPos = (QW'(1) << (ForceBits - 1)) - QW'(1);
  localparam logic [QW-1:0] ForceMaxNeg = QW'(1) << (ForceBits - 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3, ST_CMP, ST_SQGO, ST_SQWAIT,
    ST_SCMUL, ST_SCGO, ST_SCWAIT, ST_MIN, ST_ERR, ST_DGO, ST_DWAIT,
    ST_KP, ST_KDL, ST_KDH, ST_T2, ST_PM, ST_G0, ST_G1, ST_G2, ST_G3,
    ST_SAT, ST_OUT
  } state_e;

  state_e                    state_q;
  logic [1:0]                ax_q;
  logic                      first_q;
  logic signed [P-1:0]       meas_q   [3];
  logic signed [P-1:0]       origin_q [3];
  logic signed [RW-1:0]      ref_q    [3];
  logic signed [EW-1:0]      err_q    [3];
  logic signed [DFW-1:0]     diff_q   [3];
  logic signed [EW-1:0]      prev_q   [3];
  logic [SQW-1:0]            r2_q;
  logic [RTW-1:0]            root_q;
  logic [DCW-1:0]            dm_q;
  logic [T1W-1:0]            t1_q;
  logic [T2W-1:0]            t2_q;
  logic [PMW-1:0]            pm_q;
  logic                      pneg_q;
  logic [ACW-1:0]            acc_q;
  logic signed [ForceBits-1:0] force_q [3];
  logic signed [ForceBits-1:0] out_force_q [3];
  logic signed [P-1:0]       out_ref_q [3];
  logic signed [P:0]         out_err_q [3];
  logic                      out_valid_q;

  logic [GainBits-1:0]       gain_q;
  logic [GainBits-1:0]       kp_q;
  logic [GainBits-1:0]       kd_q;
  logic [PeriodBits-1:0]     per_q;
  logic [RadiusBits-1:0]     rl_q;
  logic signed [MinBits-1:0] min_q [3];

  logic signed [P-1:0]       vec_w    [3];
  logic signed [P-1:0]       meas_w   [3];
  logic signed [RW-1:0]      sum_w    [3];
  logic [RW-1:0]             mag_w    [3];
  logic signed [RW-1:0]      min_w    [3];
  logic signed [EW-1:0]      err_w    [3];
  logic signed [DFW-1:0]     diff_w   [3];
  logic [EW-1:0]             err_mag;
  logic [DFW-1:0]            diff_mag;
  logic [MW-1:0]             mul_a;
  logic [MW-1:0]             mul_b;
  logic [PW-1:0]             mul_p;
  logic                      div_start;
  logic [NW-1:0]             div_num;
  logic [DENW-1:0]           div_den;
  logic [NW-1:0]             div_quot;
  pdpr_unit_sts_t            div_sts;
  logic                      sq_start;
  logic [RTW-1:0]            sq_root;
  pdpr_unit_sts_t            sq_sts;
  logic [NW:0]               quot_x;
  logic [DCW-1:0]            dm_w;
  logic [RW-1:0]             scale_w;
  logic signed [PDW-1:0]     s1_w;
  logic signed [PDW-1:0]     s2_w;
  logic signed [PDW-1:0]     pd_w;
  logic [QW-1:0]             q_w;
  logic signed [ForceBits-1:0] force_w;
  logic                      in_acc;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    vec_w[0]  = vector_x_i;
    vec_w[1]  = vector_y_i;
    vec_w[2]  = vector_z_i;
    meas_w[0] = meas_x_i;
    meas_w[1] = meas_y_i;
    meas_w[2] = meas_z_i;
    for (int i = 0; i < 3; i++) begin
      sum_w[i]  = RW'(origin_q[i]) + RW'(vec_w[i]);
      mag_w[i]  = ref_q[i][RW-1] ? RW'(-ref_q[i]) : RW'(ref_q[i]);
      min_w[i]  = RW'(min_q[i]);
      err_w[i]  = EW'(ref_q[i]) - EW'(meas_q[i]);
      diff_w[i] = DFW'(err_w[i]) - DFW'(first_q ? err_w[i] : prev_q[i]);
    end
    err_mag  = err_q[ax_q][EW-1] ? EW'(-err_q[ax_q]) : EW'(err_q[ax_q]);
    diff_mag = diff_q[ax_q][DFW-1] ? DFW'(-diff_q[ax_q]) : DFW'(diff_q[ax_q]);
    quot_x   = {1'b0, div_quot};
    dm_w     = (quot_x > DerivCap) ? DCW'(DerivCap) : quot_x[DCW-1:0];
    scale_w  = div_quot[RW-1:0];
    s1_w     = signed'(PDW'(t1_q));
    s2_w     = signed'(PDW'(t2_q));
    if (err_q[ax_q][EW-1]) begin
      s1_w = -s1_w;
    end
    if (diff_q[ax_q][DFW-1]) begin
      s2_w = -s2_w;
    end
    pd_w = s1_w + s2_w;
    q_w  = acc_q[ACW-1:GainShift];
    if (pneg_q) begin
      force_w = (q_w > ForceMaxNeg) ? signed'(ForceBits'(ForceMaxNeg))
                                    : signed'(ForceBits'(-q_w));
    end else begin
      force_w = (q_w > ForceMaxPos) ? signed'(ForceBits'(ForceMaxPos))
                                    : signed'(ForceBits'(q_w));
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ0: begin
        mul_a = MW'(mag_w[0]);
        mul_b = MW'(mag_w[0]);
      end
      ST_SQ1: begin
        mul_a = MW'(mag_w[1]);
        mul_b = MW'(mag_w[1]);
      end
      ST_SQ2: begin
        mul_a = MW'(mag_w[2]);
        mul_b = MW'(mag_w[2]);
      end
      ST_SQ3: begin
        mul_a = MW'(rl_q);
        mul_b = MW'(rl_q);
      end
      ST_SCMUL: begin
        mul_a = MW'(mag_w[ax_q]);
        mul_b = MW'(rl_q);
      end
      ST_KP: begin
        mul_a = MW'(kp_q);
        mul_b = MW'(err_mag);
      end
      ST_KDL: begin
        mul_a = MW'(kd_q);
        mul_b = MW'(dm_q[ChunkBits-1:0]);
      end
      ST_KDH: begin
        mul_a = MW'(kd_q);
        mul_b = MW'(dm_q[DCW-1:ChunkBits]);
      end
      ST_G0: begin
        mul_a = MW'(gain_q);
        mul_b = MW'(pm_q[ChunkBits-1:0]);
      end
      ST_G1: begin
        mul_a = MW'(gain_q);
        mul_b = MW'(pm_q[2*ChunkBits-1:ChunkBits]);
      end
      ST_G2: begin
        mul_a = MW'(gain_q);
        mul_b = MW'(pm_q[PMW-1:2*ChunkBits]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_start = (state_q == ST_SCGO) || (state_q == ST_DGO);
  assign div_num   = (state_q == ST_SCGO) ? NW'(mul_p)
                                          : {diff_mag, {DerivShift{1'b0}}};
  assign div_den   = (state_q == ST_SCGO) ? DENW'(root_q)
                   : ((per_q == '0) ? DENW'(1) : DENW'(per_q));
  assign sq_start  = (state_q == ST_SQGO);

  pdpr_mul #(.MW(MW)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  pdpr_div #(.NW(NW), .DW(DENW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (div_quot),
    .sts_o   (div_sts)
  );

  pdpr_sqrt #(.SW(SQW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (r2_q),
    .root_o  (sq_root),
    .sts_o   (sq_sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ax_q        <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
      gain_q      <= '0;
      kp_q        <= '0;
      kd_q        <= '0;
      per_q       <= 24'd16777;
      rl_q        <= 19'd49152;
      min_q[0]    <= -20'sd13107;
      min_q[1]    <= 20'sd13107;
      min_q[2]    <= 20'sd6554;
      for (int i = 0; i < 3; i++) begin
        origin_q[i] <= '0;
        prev_q[i]   <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (pdpr_reg_e'(cfg_index_i))
          REG_GAIN_SCALE:    gain_q   <= cfg_data_i[GainBits-1:0];
          REG_KP:            kp_q     <= cfg_data_i[GainBits-1:0];
          REG_KD:            kd_q     <= cfg_data_i[GainBits-1:0];
          REG_SAMPLE_PERIOD: per_q    <= cfg_data_i[PeriodBits-1:0];
          REG_RADIUS_LIMIT:  rl_q     <= cfg_data_i[RadiusBits-1:0];
          REG_MIN_X:         min_q[0] <= signed'(cfg_data_i[MinBits-1:0]);
          REG_MIN_Y:         min_q[1] <= signed'(cfg_data_i[MinBits-1:0]);
          REG_MIN_Z:         min_q[2] <= signed'(cfg_data_i[MinBits-1:0]);
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            first_q <= first_run_i;
            for (int i = 0; i < 3; i++) begin
              meas_q[i] <= meas_w[i];
            end
            if (op_i) begin
              for (int i = 0; i < 3; i++) begin
                origin_q[i] <= vec_w[i];
              end
            end else begin
              for (int i = 0; i < 3; i++) begin
                ref_q[i] <= first_run_i ? RW'(vec_w[i]) : sum_w[i];
              end
              state_q <= first_run_i ? ST_ERR : ST_SQ0;
            end
          end
        end
        ST_SQ0: state_q <= ST_SQ1;
        ST_SQ1: begin
          r2_q    <= SQW'(mul_p);
          state_q <= ST_SQ2;
        end
        ST_SQ2: begin
          r2_q    <= r2_q + SQW'(mul_p);
          state_q <= ST_SQ3;
        end
        ST_SQ3: begin
          r2_q    <= r2_q + SQW'(mul_p);
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          state_q <= (PW'(r2_q) > mul_p) ? ST_SQGO : ST_MIN;
        end
        ST_SQGO: state_q <= ST_SQWAIT;
        ST_SQWAIT: begin
          if (sq_sts.done) begin
            root_q  <= (sq_root == '0) ? RTW'(1) : sq_root;
            ax_q    <= '0;
            state_q <= ST_SCMUL;
          end
        end
        ST_SCMUL: state_q <= ST_SCGO;
        ST_SCGO:  state_q <= ST_SCWAIT;
        ST_SCWAIT: begin
          if (div_sts.done) begin
            ref_q[ax_q] <= ref_q[ax_q][RW-1] ? signed'(RW'(-scale_w)) : signed'(scale_w);
            if (ax_q == 2'd2) begin
              state_q <= ST_MIN;
            end else begin
              ax_q    <= ax_q + 2'd1;
              state_q <= ST_SCMUL;
            end
          end
        end
        ST_MIN: begin
          for (int i = 0; i < 3; i++) begin
            if (ref_q[i] < min_w[i]) begin
              ref_q[i] <= min_w[i];
            end
          end
          state_q <= ST_ERR;
        end
        ST_ERR: begin
          for (int i = 0; i < 3; i++) begin
            err_q[i]  <= err_w[i];
            diff_q[i] <= diff_w[i];
            prev_q[i] <= err_w[i];
          end
          ax_q    <= '0;
          state_q <= ST_DGO;
        end
        ST_DGO: state_q <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_sts.done) begin
            dm_q    <= dm_w;
            state_q <= ST_KP;
          end
        end
        ST_KP: state_q <= ST_KDL;
        ST_KDL: begin
          t1_q    <= T1W'(mul_p);
          state_q <= ST_KDH;
        end
        ST_KDH: begin
          t2_q    <= T2W'(mul_p);
          state_q <= ST_T2;
        end
        ST_T2: begin
          t2_q    <= t2_q + (T2W'(mul_p) << ChunkBits);
          state_q <= ST_PM;
        end
        ST_PM: begin
          pneg_q  <= pd_w[PDW-1];
          pm_q    <= pd_w[PDW-1] ? PMW'(-pd_w) : PMW'(pd_w);
          state_q <= ST_G0;
        end
        ST_G0: state_q <= ST_G1;
        ST_G1: begin
          acc_q   <= ACW'(mul_p);
          state_q <= ST_G2;
        end
        ST_G2: begin
          acc_q   <= acc_q + (ACW'(mul_p) << ChunkBits);
          state_q <= ST_G3;
        end
        ST_G3: begin
          acc_q   <= acc_q + (ACW'(mul_p) << (2 * ChunkBits));
          state_q <= ST_SAT;
        end
        ST_SAT: begin
          force_q[ax_q] <= force_w;
          if (ax_q == 2'd2) begin
            state_q <= ST_OUT;
          end else begin
            ax_q    <= ax_q + 2'd1;
            state_q <= ST_DGO;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            for (int i = 0; i < 3; i++) begin
              out_force_q[i] <= force_q[i];
              out_ref_q[i]   <= ref_q[i][P-1:0];
              out_err_q[i]   <= err_q[i][P:0];
            end
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign force_x_o   = out_force_q[0];
  assign force_y_o   = out_force_q[1];
  assign force_z_o   = out_force_q[2];
  assign ref_x_o     = out_ref_q[0];
  assign ref_y_o     = out_ref_q[1];
  assign ref_z_o     = out_ref_q[2];
  assign err_x_o     = out_err_q[0];
  assign err_y_o     = out_err_q[1];
  assign err_z_o     = out_err_q[2];

`ifndef SYNTHESIS
  a_div_idle_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_sts.busy)
    else $error("Divider started while busy.");

  a_sqrt_idle_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_start |-> !sq_sts.busy)
    else $error("Square root unit started while busy.");

  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op_i) |=> (state_q == ST_IDLE))
    else $error("Origin load did not complete in one cycle.");

  a_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_sts.done |-> (sq_root != '0))
    else $error("Zero radius on a clipped reference.");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) |=> out_valid_q)
    else $error("Finished result was not presented.");
`endif

endmodule
